// ===== rtl/lsc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsc_pkg
// shared types and constants for the lidar scan cluster centroid block
// ----------------------------------------------------------------------------
package lsc_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_ANGLE_START   = 3'd0,
        CFG_ANGLE_STEP    = 3'd1,
        CFG_RANGE_LOWER   = 3'd2,
        CFG_RANGE_UPPER   = 3'd3,
        CFG_JOIN_DISTANCE = 3'd4,
        CFG_MIN_POINTS    = 3'd5
    } lsc_cfg_idx_t;

    localparam int CFG_DATA_W = 16;
    localparam int COUNT_W    = 13;
    localparam int ID_W       = 12;
    localparam int COORD_W    = 17;
    localparam int SUM_W      = 30;
    localparam int COUNT_CAP  = 4096;

    // quarter-wave sine polynomial coefficients, q30
    localparam logic [31:0] COEF_A = 32'd1686629713;
    localparam logic [31:0] COEF_B = 32'd688904866;
    localparam logic [31:0] COEF_C = 32'd76016977;
    localparam logic [31:0] Q30_ONE = 32'd1073741824;
    localparam logic [15:0] QUARTER_TURN = 16'd16384;

    // classified beam passed from front to back
    typedef struct packed {
        logic [15:0] range;
        logic [15:0] angle;
        logic        point;  // beam gives a point
        logic        last;   // final beam of the scan
    } lsc_word_t;

endpackage

// ===== rtl/lsc_front.sv =====
// ----------------------------------------------------------------------------
// lsc_front
// accepts beams, screens range and flags, forms the beam angle
// ----------------------------------------------------------------------------
module lsc_front #(
    parameter int RANGE_BITS = 16
) (
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [15:0]            range_mm,
    input  logic                   reading_bad,
    input  logic [11:0]            beam_index,
    input  logic                   scan_end,
    input  logic [15:0]            angle_start,
    input  logic [15:0]            angle_step,
    input  logic [15:0]            range_lower,
    input  logic [15:0]            range_upper,
    input  logic                   q_full,
    output logic                   q_push,
    output lsc_pkg::lsc_word_t     q_word
);
    import lsc_pkg::*;

    localparam int RB = (RANGE_BITS < 16) ? RANGE_BITS : 16;
    localparam logic [15:0] RANGE_MASK = 16'((32'd1 << RB) - 32'd1);

    logic [15:0] range_eff;
    logic [27:0] step_prod;
    logic        point;

    always_comb
    begin
        range_eff = range_mm & RANGE_MASK;
        step_prod = beam_index * angle_step;
        point     = !reading_bad && (range_eff >= range_lower) && (range_eff <= range_upper);
        q_word.range = range_eff;
        q_word.angle = angle_start + step_prod[15:0];
        q_word.point = point;
        q_word.last  = scan_end;
    end

    // words that neither give a point nor end the scan are dropped here
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full && (point || scan_end);

endmodule

// ===== rtl/lsc_queue.sv =====
// ----------------------------------------------------------------------------
// lsc_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module lsc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lsc_pkg::lsc_word_t push_word,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output lsc_pkg::lsc_word_t head_word
);
    import lsc_pkg::*;

    lsc_word_t  mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head_word = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// ===== rtl/lsc_div.sv =====
// ----------------------------------------------------------------------------
// lsc_div
// bit-serial signed sum by point count divider, truncates toward zero
// ----------------------------------------------------------------------------
module lsc_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [lsc_pkg::SUM_W-1:0]     dividend,
    input  logic        [lsc_pkg::COUNT_W-1:0]   divisor,
    output logic                                 busy,
    output logic signed [lsc_pkg::COORD_W-1:0]   quotient
);
    import lsc_pkg::*;

    localparam int CNT_W = $clog2(SUM_W);

    logic               busy_reg, busy_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0]   quo_reg, quo_next;
    logic [COUNT_W-1:0] div_reg, div_next;
    logic               neg_reg, neg_next;
    logic [COUNT_W:0]   trial;
    logic               ge;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        trial     = {rem_reg, quo_reg[SUM_W-1]};
        ge        = (trial >= {1'b0, div_reg});
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
            div_next  = divisor;
            neg_next  = dividend[SUM_W-1];
        end
        else if (busy_reg)
        begin
            rem_next = ge ? COUNT_W'(trial - {1'b0, div_reg}) : trial[COUNT_W-1:0];
            quo_next = {quo_reg[SUM_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            div_reg  <= '0;
            neg_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            div_reg  <= div_next;
            neg_reg  <= neg_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? -$signed(quo_reg[COORD_W-1:0]) : $signed(quo_reg[COORD_W-1:0]);

endmodule

// ===== rtl/lsc_back.sv =====
// ----------------------------------------------------------------------------
// lsc_back
// per-beam sequencer: trig, polar to cartesian, join test, cluster close
// ----------------------------------------------------------------------------
module lsc_back #(
    parameter int MAX_BEAMS      = 4096,
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_not_empty,
    input  lsc_pkg::lsc_word_t                  q_word,
    output logic                                q_pop,
    input  logic [15:0]                         join_distance,
    input  logic [lsc_pkg::COUNT_W-1:0]         min_points,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                object_valid,
    output logic [lsc_pkg::ID_W-1:0]            object_id,
    output logic signed [lsc_pkg::COORD_W-1:0]  centroid_x,
    output logic signed [lsc_pkg::COORD_W-1:0]  centroid_y,
    output logic [lsc_pkg::COUNT_W-1:0]         point_count,
    output logic                                scan_done
);
    import lsc_pkg::*;

    localparam int F   = TRIG_FRAC_BITS;
    localparam int CAP = (MAX_BEAMS < COUNT_CAP) ? MAX_BEAMS : COUNT_CAP;
    localparam logic [COUNT_W-1:0] CAP_CNT = COUNT_W'(CAP);
    localparam logic [31:0] RND_S = 32'd1 << (29 - F);
    localparam logic [63:0] RND_M = 64'd1 << (F - 1);

    typedef enum logic [14:0] {
        ST_IDLE  = 15'b000000000000001,
        ST_SQ    = 15'b000000000000010,
        ST_C     = 15'b000000000000100,
        ST_B     = 15'b000000000001000,
        ST_A     = 15'b000000000010000,
        ST_R     = 15'b000000000100000,
        ST_S     = 15'b000000001000000,
        ST_JD    = 15'b000000010000000,
        ST_DX    = 15'b000000100000000,
        ST_DY    = 15'b000001000000000,
        ST_JN    = 15'b000010000000000,
        ST_ADD   = 15'b000100000000000,
        ST_CLOSE = 15'b001000000000000,
        ST_DIV   = 15'b010000000000000,
        ST_EMIT  = 15'b100000000000000
    } lsc_state_t;

    lsc_state_t state_reg, state_next;
    logic        cos_reg, cos_next;
    logic [15:0] rng_reg, rng_next;
    logic [15:0] ang_reg, ang_next;
    logic        end_reg, end_next;
    logic        final_reg, final_next;
    logic        join_reg, join_next;
    logic        qual_reg, qual_next;
    logic [31:0] z2_reg, z2_next;
    logic [31:0] jd2_reg, jd2_next;
    logic [33:0] dx2_reg, dx2_next;
    logic [63:0] prod_reg, prod_next;
    logic signed [COORD_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [COORD_W-1:0] last_x_reg, last_x_next, last_y_reg, last_y_next;
    logic        have_last_reg, have_last_next;
    logic signed [SUM_W-1:0] sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [ID_W-1:0]    sent_reg, sent_next;

    logic        out_valid_reg, out_valid_next;
    logic        obj_valid_reg, obj_valid_next;
    logic [ID_W-1:0] obj_id_reg, obj_id_next;
    logic signed [COORD_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [COUNT_W-1:0] cnt_out_reg, cnt_out_next;
    logic        done_reg, done_next;

    logic [15:0] ph_ang;
    logic [14:0] qpos;
    logic [31:0] t_hi, s_val, m_val, mul_a, mul_b;
    logic [COORD_W-1:0] mag;
    logic signed [COORD_W-1:0] coord;
    logic signed [COORD_W:0] dx_s, dy_s;
    logic [COORD_W-1:0] dx_abs, dy_abs;
    logic [34:0] gap_sq;
    logic [COUNT_W-1:0] need;
    logic        qual;
    logic        div_start, div_busy_x, div_busy_y;
    logic signed [COORD_W-1:0] qx, qy;
    logic [63:0] mag_wide;

    lsc_div u_div_x (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sum_x_reg),
        .divisor(count_reg), .busy(div_busy_x), .quotient(qx)
    );

    lsc_div u_div_y (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sum_y_reg),
        .divisor(count_reg), .busy(div_busy_y), .quotient(qy)
    );

    always_comb
    begin
        // quadrant fold of the current trig angle
        ph_ang   = ang_reg + (cos_reg ? QUARTER_TURN : 16'd0);
        qpos     = ph_ang[14] ? (15'd16384 - {1'b0, ph_ang[13:0]}) : {1'b0, ph_ang[13:0]};
        t_hi     = prod_reg[61:30];
        s_val    = prod_reg[45:14];
        if (s_val > Q30_ONE)
        begin
            s_val = Q30_ONE;
        end
        m_val    = (s_val + RND_S) >> (30 - F);
        mag_wide = (prod_reg + RND_M) >> F;
        mag      = mag_wide[COORD_W-1:0];
        coord    = ph_ang[15] ? -$signed(mag) : $signed(mag);
        dx_s     = {x_reg[COORD_W-1], x_reg} - {last_x_reg[COORD_W-1], last_x_reg};
        dy_s     = {y_reg[COORD_W-1], y_reg} - {last_y_reg[COORD_W-1], last_y_reg};
        dx_abs   = dx_s[COORD_W] ? COORD_W'(-dx_s) : dx_s[COORD_W-1:0];
        dy_abs   = dy_s[COORD_W] ? COORD_W'(-dy_s) : dy_s[COORD_W-1:0];
        gap_sq   = {1'b0, dx2_reg} + {1'b0, prod_reg[33:0]};
        need     = (min_points == '0) ? COUNT_W'(1) : min_points;
        qual     = (count_reg != '0) && (count_reg >= need);

        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQ:
            begin
                mul_a = {17'd0, qpos};
                mul_b = {17'd0, qpos};
            end
            ST_C:
            begin
                mul_a = COEF_C;
                mul_b = {prod_reg[29:0], 2'b00};
            end
            ST_B:
            begin
                mul_a = COEF_B - t_hi;
                mul_b = z2_reg;
            end
            ST_A:
            begin
                mul_a = COEF_A - t_hi;
                mul_b = {17'd0, qpos};
            end
            ST_R:
            begin
                mul_a = {16'd0, rng_reg};
                mul_b = m_val;
            end
            ST_JD:
            begin
                mul_a = {16'd0, join_distance};
                mul_b = {16'd0, join_distance};
            end
            ST_DX:
            begin
                mul_a = {15'd0, dx_abs};
                mul_b = {15'd0, dx_abs};
            end
            ST_DY:
            begin
                mul_a = {15'd0, dy_abs};
                mul_b = {15'd0, dy_abs};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;

        state_next     = state_reg;
        cos_next       = cos_reg;
        rng_next       = rng_reg;
        ang_next       = ang_reg;
        end_next       = end_reg;
        final_next     = final_reg;
        join_next      = join_reg;
        qual_next      = qual_reg;
        z2_next        = z2_reg;
        jd2_next       = jd2_reg;
        dx2_next       = dx2_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        last_x_next    = last_x_reg;
        last_y_next    = last_y_reg;
        have_last_next = have_last_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        count_next     = count_reg;
        sent_next      = sent_reg;
        q_pop          = 1'b0;
        div_start      = 1'b0;

        out_valid_next = out_valid_reg && !out_ready;
        obj_valid_next = obj_valid_reg;
        obj_id_next    = obj_id_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cnt_out_next   = cnt_out_reg;
        done_next      = done_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop    = 1'b1;
                    rng_next = q_word.range;
                    ang_next = q_word.angle;
                    end_next = q_word.last;
                    cos_next = 1'b1;
                    if (q_word.point)
                    begin
                        state_next = ST_SQ;
                    end
                    else
                    begin
                        final_next = 1'b1;
                        state_next = ST_CLOSE;
                    end
                end
            end
            ST_SQ:
            begin
                state_next = ST_C;
            end
            ST_C:
            begin
                z2_next    = {prod_reg[29:0], 2'b00};
                state_next = ST_B;
            end
            ST_B:
            begin
                state_next = ST_A;
            end
            ST_A:
            begin
                state_next = ST_R;
            end
            ST_R:
            begin
                state_next = ST_S;
            end
            ST_S:
            begin
                if (cos_reg)
                begin
                    x_next     = coord;
                    cos_next   = 1'b0;
                    state_next = ST_SQ;
                end
                else
                begin
                    y_next = coord;
                    if (have_last_reg)
                    begin
                        state_next = ST_JD;
                    end
                    else
                    begin
                        join_next  = 1'b0;
                        state_next = ST_ADD;
                    end
                end
            end
            ST_JD:
            begin
                state_next = ST_DX;
            end
            ST_DX:
            begin
                jd2_next   = prod_reg[31:0];
                state_next = ST_DY;
            end
            ST_DY:
            begin
                dx2_next   = prod_reg[33:0];
                state_next = ST_JN;
            end
            ST_JN:
            begin
                join_next = (gap_sq < {3'd0, jd2_reg}) && (count_reg < CAP_CNT);
                if ((gap_sq < {3'd0, jd2_reg}) && (count_reg < CAP_CNT))
                begin
                    state_next = ST_ADD;
                end
                else
                begin
                    final_next = 1'b0;
                    state_next = ST_CLOSE;
                end
            end
            ST_ADD:
            begin
                if (join_reg)
                begin
                    sum_x_next = sum_x_reg + SUM_W'(x_reg);
                    sum_y_next = sum_y_reg + SUM_W'(y_reg);
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    sum_x_next = SUM_W'(x_reg);
                    sum_y_next = SUM_W'(y_reg);
                    count_next = COUNT_W'(1);
                end
                last_x_next    = x_reg;
                last_y_next    = y_reg;
                have_last_next = 1'b1;
                if (end_reg)
                begin
                    final_next = 1'b1;
                    state_next = ST_CLOSE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLOSE:
            begin
                qual_next = qual;
                if (qual)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else if (final_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_ADD;
                end
            end
            ST_DIV:
            begin
                if (!div_busy_x && !div_busy_y)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    obj_valid_next = qual_reg;
                    obj_id_next    = qual_reg ? sent_reg : '0;
                    cx_next        = qual_reg ? qx : '0;
                    cy_next        = qual_reg ? qy : '0;
                    cnt_out_next   = qual_reg ? count_reg : '0;
                    done_next      = final_reg;
                    if (qual_reg)
                    begin
                        sent_next = sent_reg + 1'b1;
                    end
                    if (final_reg)
                    begin
                        have_last_next = 1'b0;
                        last_x_next    = '0;
                        last_y_next    = '0;
                        sum_x_next     = '0;
                        sum_y_next     = '0;
                        count_next     = '0;
                        sent_next      = '0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_ADD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cos_reg       <= 1'b0;
            end_reg       <= 1'b0;
            final_reg     <= 1'b0;
            join_reg      <= 1'b0;
            qual_reg      <= 1'b0;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            have_last_reg <= 1'b0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            count_reg     <= '0;
            sent_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cos_reg       <= cos_next;
            end_reg       <= end_next;
            final_reg     <= final_next;
            join_reg      <= join_next;
            qual_reg      <= qual_next;
            last_x_reg    <= last_x_next;
            last_y_reg    <= last_y_next;
            have_last_reg <= have_last_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            count_reg     <= count_next;
            sent_reg      <= sent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rng_reg       <= rng_next;
        ang_reg       <= ang_next;
        z2_reg        <= z2_next;
        jd2_reg       <= jd2_next;
        dx2_reg       <= dx2_next;
        prod_reg      <= prod_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        obj_valid_reg <= obj_valid_next;
        obj_id_reg    <= obj_id_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        cnt_out_reg   <= cnt_out_next;
        done_reg      <= done_next;
    end

    assign out_valid    = out_valid_reg;
    assign object_valid = obj_valid_reg;
    assign object_id    = obj_id_reg;
    assign centroid_x   = cx_reg;
    assign centroid_y   = cy_reg;
    assign point_count  = cnt_out_reg;
    assign scan_done    = done_reg;

endmodule

// ===== rtl/lidar_scan_cluster_centroids.sv =====
// ----------------------------------------------------------------------------
// lidar_scan_cluster_centroids
// groups lidar beams into clusters and reports each cluster's centroid
// ----------------------------------------------------------------------------
// sequence: a point beam in the back runs two trig evaluations of six steps
//   each on one shared 32x32 multiplier, then the join test (not for a
//   scan's first point); each reported cluster adds the bit-serial 30-bit
//   centroid divide and the result write
// flow: a beam holds the back until done, plus result stalls; screened-out
//   words never reach it; a two-word queue decouples input
// reset: rst_n clears the scan state and control; config regs get defaults
module lidar_scan_cluster_centroids #(
    parameter int MAX_BEAMS      = 4096,
    parameter int RANGE_BITS     = 16,
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // beam input words
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [15:0]                         range_mm,
    input  logic                                reading_bad,
    input  logic [11:0]                         beam_index,
    input  logic                                scan_end,
    // result words
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                object_valid,
    output logic [lsc_pkg::ID_W-1:0]            object_id,
    output logic signed [lsc_pkg::COORD_W-1:0]  centroid_x,
    output logic signed [lsc_pkg::COORD_W-1:0]  centroid_y,
    output logic [lsc_pkg::COUNT_W-1:0]         point_count,
    output logic                                scan_done,
    // configuration write port
    input  logic                                cfg_write,
    input  logic [2:0]                          cfg_index,
    input  logic [lsc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import lsc_pkg::*;

    // configuration registers
    logic [15:0]        angle_start_reg, angle_start_next;
    logic [15:0]        angle_step_reg, angle_step_next;
    logic [15:0]        range_lower_reg, range_lower_next;
    logic [15:0]        range_upper_reg, range_upper_next;
    logic [15:0]        join_dist_reg, join_dist_next;
    logic [COUNT_W-1:0] min_points_reg, min_points_next;

    // front to queue to back
    logic      q_push, q_full, q_pop, q_not_empty;
    lsc_word_t push_word, head_word;

    always_comb
    begin
        angle_start_next = angle_start_reg;
        angle_step_next  = angle_step_reg;
        range_lower_next = range_lower_reg;
        range_upper_next = range_upper_reg;
        join_dist_next   = join_dist_reg;
        min_points_next  = min_points_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_ANGLE_START:   angle_start_next = cfg_data;
                CFG_ANGLE_STEP:    angle_step_next  = cfg_data;
                CFG_RANGE_LOWER:   range_lower_next = cfg_data;
                CFG_RANGE_UPPER:   range_upper_next = cfg_data;
                CFG_JOIN_DISTANCE: join_dist_next   = cfg_data;
                CFG_MIN_POINTS:    min_points_next  = cfg_data[COUNT_W-1:0];
                default:           ;  // unmapped index, write ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_start_reg <= 16'd0;
            angle_step_reg  <= 16'd182;
            range_lower_reg <= 16'd0;
            range_upper_reg <= 16'hFFFF;
            join_dist_reg   <= 16'd500;
            min_points_reg  <= COUNT_W'(3);
        end
        else
        begin
            angle_start_reg <= angle_start_next;
            angle_step_reg  <= angle_step_next;
            range_lower_reg <= range_lower_next;
            range_upper_reg <= range_upper_next;
            join_dist_reg   <= join_dist_next;
            min_points_reg  <= min_points_next;
        end
    end

    // screening and beam angle
    lsc_front #(
        .RANGE_BITS(RANGE_BITS)
    ) u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .range_mm    (range_mm),
        .reading_bad (reading_bad),
        .beam_index  (beam_index),
        .scan_end    (scan_end),
        .angle_start (angle_start_reg),
        .angle_step  (angle_step_reg),
        .range_lower (range_lower_reg),
        .range_upper (range_upper_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_word      (push_word)
    );

    // lets the input side keep accepting while the back works
    lsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (push_word),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_word (head_word)
    );

    // trig, clustering and centroid reporting
    lsc_back #(
        .MAX_BEAMS      (MAX_BEAMS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_word        (head_word),
        .q_pop         (q_pop),
        .join_distance (join_dist_reg),
        .min_points    (min_points_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .object_valid  (object_valid),
        .object_id     (object_id),
        .centroid_x    (centroid_x),
        .centroid_y    (centroid_y),
        .point_count   (point_count),
        .scan_done     (scan_done)
    );

endmodule
